// ===== src/hse_pkg.sv =====
package hse_pkg;

   // defaults for the top-level parameters
   localparam int DEF_MAX_CODE_LEN = 32;
   localparam int DEF_SYMBOL_COUNT = 256;

   // fixed field widths
   localparam int CODE_FIELD_W = 32;
   localparam int LEN_FIELD_W  = 6;
   localparam int BYTE_W       = 8;
   localparam int PAD_W        = 3;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

   // command codes
   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_DATA  = 2'd1;
   localparam logic [1:0] CMD_FLUSH = 2'd2;

   typedef struct packed {
      logic [1:0]              cmd;
      logic [7:0]              symbol;
      logic [CODE_FIELD_W-1:0] code_bits;
      logic [LEN_FIELD_W-1:0]  code_length;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              has_byte;
      logic              end_of_stream;
      logic [PAD_W-1:0]  pad_bits;
   } rsp_type;

   // one queued job for the bit packer
   typedef struct packed {
      logic                    flush;
      logic [CODE_FIELD_W-1:0] code;
      logic [LEN_FIELD_W-1:0]  len;
   } qent_type;

   // usable code length: parameter limit or the code field width
   function automatic int eff_len(input int max_len);
      int r;
      r = (max_len < CODE_FIELD_W) ? max_len : CODE_FIELD_W;
      return r;
   endfunction

endpackage

// ===== src/hse_front.sv =====
module hse_front #(
   parameter int MAX_CODE_LEN = hse_pkg::DEF_MAX_CODE_LEN,
   parameter int SYMBOL_COUNT = hse_pkg::DEF_SYMBOL_COUNT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  hse_pkg::req_type        req_item,
   input  logic [hse_pkg::QLVL_W-1:0] q_level,
   output logic                    q_push,
   output hse_pkg::qent_type       q_entry
);
   import hse_pkg::*;

   localparam int EFF_LEN = eff_len(MAX_CODE_LEN);
   localparam int LW      = $clog2(EFF_LEN + 1);
   localparam int IDX_W   = $clog2(SYMBOL_COUNT);
   localparam int ENT_W   = EFF_LEN + LW;

   logic                 accept;
   logic                 in_range;
   logic [IDX_W-1:0]     idx;
   logic                 tbl_wr;
   logic [LEN_FIELD_W-1:0] len_cl;
   logic [63:0]          mask64;
   logic [CODE_FIELD_W-1:0] code_masked;

   logic [ENT_W-1:0]     tbl_mem [SYMBOL_COUNT];
   logic [SYMBOL_COUNT-1:0] tbl_vld_ff, tbl_vld_in;
   logic [ENT_W-1:0]     rd_ff;
   logic                 s1_vld_ff, s1_vld_in;
   logic                 s1_flush_ff;
   logic                 s1_hit_ff;
   logic [EFF_LEN-1:0]   rd_code;
   logic [LW-1:0]        rd_len;

   // classify the incoming item
   assign accept   = req_valid && !req_stall;
   assign in_range = (int'(req_item.symbol) < SYMBOL_COUNT);
   assign idx      = req_item.symbol[IDX_W-1:0];
   assign tbl_wr   = accept && (req_item.cmd == CMD_LOAD) && in_range;

   // room for the item in stage one plus the next one
   assign req_stall = (q_level + QLVL_W'(s1_vld_ff)) >= QLVL_W'(QUEUE_DEPTH);

   // saturate and mask the loaded code
   always_comb begin
      len_cl = (req_item.code_length > LEN_FIELD_W'(EFF_LEN)) ?
               LEN_FIELD_W'(EFF_LEN) : req_item.code_length;
      mask64 = (64'd1 << len_cl) - 64'd1;
      code_masked = req_item.code_bits & mask64[CODE_FIELD_W-1:0];
   end

   // code table storage and registered read
   always_ff @(posedge clock) begin
      if (tbl_wr) begin
         tbl_mem[idx] <= {code_masked[EFF_LEN-1:0], len_cl[LW-1:0]};
      end
      if (accept) begin
         rd_ff <= tbl_mem[idx];
      end
   end

   // per-entry valid bits, cleared at reset
   always_comb begin
      tbl_vld_in = tbl_vld_ff;
      if (tbl_wr) begin
         tbl_vld_in[idx] = 1'b1;
      end
   end

   // stage one keeps data and flush items only
   assign s1_vld_in = accept &&
                      (((req_item.cmd == CMD_DATA) && in_range) ||
                       (req_item.cmd == CMD_FLUSH));

   always_ff @(posedge clock) begin
      if (reset) begin
         tbl_vld_ff <= '0;
         s1_vld_ff  <= 1'b0;
      end else begin
         tbl_vld_ff <= tbl_vld_in;
         s1_vld_ff  <= s1_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_flush_ff <= (req_item.cmd == CMD_FLUSH);
         s1_hit_ff   <= in_range && tbl_vld_ff[idx];
      end
   end

   // drop data items whose symbol emits nothing
   assign rd_code = rd_ff[ENT_W-1:LW];
   assign rd_len  = rd_ff[LW-1:0];

   always_comb begin
      q_push = s1_vld_ff && (s1_flush_ff || (s1_hit_ff && (rd_len != '0)));
      q_entry.flush = s1_flush_ff;
      q_entry.code  = CODE_FIELD_W'(rd_code);
      q_entry.len   = LEN_FIELD_W'(rd_len);
   end

endmodule

// ===== src/hse_queue.sv =====
module hse_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  hse_pkg::qent_type          push_entry,
   input  logic                       pop,
   output hse_pkg::qent_type          head,
   output logic                       empty,
   output logic [hse_pkg::QLVL_W-1:0] level
);
   import hse_pkg::*;

   qent_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QLVL_W-1:0] level_ff, level_in;
   logic              do_pop;

   assign empty  = (level_ff == '0);
   assign level  = level_ff;
   assign head   = slot_ff[rd_ptr_ff];
   assign do_pop = pop && !empty;

   // pointer and fill level update
   always_comb begin
      wr_ptr_in = push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      level_in  = level_ff + QLVL_W'(push) - QLVL_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== src/hse_back.sv =====
module hse_back #(
   parameter int MAX_CODE_LEN = hse_pkg::DEF_MAX_CODE_LEN
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  hse_pkg::qent_type q_head,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output hse_pkg::rsp_type  rsp_item
);
   import hse_pkg::*;

   localparam int EFF_LEN = eff_len(MAX_CODE_LEN);
   localparam int ACC_W   = EFF_LEN + BYTE_W - 1;
   localparam int CNT_W   = $clog2(ACC_W + 1);

   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_vld_ff, rsp_vld_in;
   rsp_type          rsp_ff, rsp_in;

   logic             out_free;
   logic             emit_byte;
   logic             last_byte;
   logic             pop_data;
   logic             pop_flush;
   logic [CNT_W-1:0] cnt_base;
   logic [CNT_W-1:0] byte_pos;
   logic [PAD_W-1:0] pad;

   // output register takes a new item when empty or being drained
   assign out_free  = !rsp_vld_ff || !rsp_stall;
   assign emit_byte = (cnt_ff >= CNT_W'(BYTE_W)) && out_free;
   assign last_byte = (int'(cnt_ff) < 2 * BYTE_W);

   // next job may start with the last byte of the current one
   assign pop_data  = !q_empty && !q_head.flush &&
                      ((cnt_ff < CNT_W'(BYTE_W)) || (emit_byte && last_byte));
   assign pop_flush = !q_empty && q_head.flush &&
                      (cnt_ff < CNT_W'(BYTE_W)) && out_free;
   assign q_pop     = pop_data || pop_flush;

   assign byte_pos = cnt_ff - CNT_W'(BYTE_W);
   assign pad      = PAD_W'(4'd8 - 4'(cnt_ff));
   assign cnt_base = emit_byte ? byte_pos : cnt_ff;

   // accumulator and pending count
   always_comb begin
      acc_in = acc_ff;
      cnt_in = cnt_base;
      if (pop_data) begin
         acc_in = (acc_ff << q_head.len) | ACC_W'(q_head.code);
         cnt_in = cnt_base + CNT_W'(q_head.len);
      end else if (pop_flush) begin
         acc_in = '0;
         cnt_in = '0;
      end
   end

   // result item selection
   always_comb begin
      rsp_in     = rsp_ff;
      rsp_vld_in = rsp_vld_ff && rsp_stall;
      if (emit_byte) begin
         rsp_vld_in             = 1'b1;
         rsp_in.out_byte        = BYTE_W'(acc_ff >> byte_pos);
         rsp_in.has_byte        = 1'b1;
         rsp_in.end_of_stream   = 1'b0;
         rsp_in.pad_bits        = '0;
      end else if (pop_flush) begin
         rsp_vld_in             = 1'b1;
         rsp_in.end_of_stream   = 1'b1;
         if (cnt_ff == '0) begin
            rsp_in.out_byte     = '0;
            rsp_in.has_byte     = 1'b0;
            rsp_in.pad_bits     = '0;
         end else begin
            rsp_in.out_byte     = BYTE_W'(acc_ff << pad);
            rsp_in.has_byte     = 1'b1;
            rsp_in.pad_bits     = pad;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff     <= '0;
         cnt_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         acc_ff     <= acc_in;
         cnt_ff     <= cnt_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_item  = rsp_ff;

endmodule

// ===== src/huffman_stream_encode_core.sv =====
// Huffman stream encoder with a loadable code table and an MSB-first byte packer.
// Input channel req_: one item per accepted cycle (req_valid high, req_stall low).
//   cmd load writes a symbol's code word and length into the table, no result;
//   cmd data appends the symbol's code and yields one result per completed byte;
//   cmd flush yields one result with the final left-aligned partial byte,
//   has_byte, end_of_stream and the pad count, and empties the packer.
// Result channel rsp_: each item is taken when rsp_valid is high and rsp_stall low.
// The front takes one item per cycle while req_stall is low; the packer may take
//   the next data item with the last byte of the current one, and it yields its
//   bytes through the one-byte result register.
// A 4-entry queue parts the table lookup from the packer; req_stall rises when
//   it and the lookup stage hold 4 items, so a stalled receiver backs up into it.
// Reset: synchronous; all table entries are marked invalid, the packer is empty
//   and no result is pending; invalid entries emit nothing. No clearing pass is needed.
module huffman_stream_encode_core #(
   parameter int MAX_CODE_LEN = hse_pkg::DEF_MAX_CODE_LEN,
   parameter int SYMBOL_COUNT = hse_pkg::DEF_SYMBOL_COUNT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  hse_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output hse_pkg::rsp_type rsp_item
);
   import hse_pkg::*;

   logic              q_push;
   logic              q_pop;
   logic              q_empty;
   qent_type          q_entry;
   qent_type          q_head;
   logic [QLVL_W-1:0] q_level;

   // lookup front
   hse_front #(
      .MAX_CODE_LEN (MAX_CODE_LEN),
      .SYMBOL_COUNT (SYMBOL_COUNT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .q_level   (q_level),
      .q_push    (q_push),
      .q_entry   (q_entry)
   );

   // job queue
   hse_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .empty      (q_empty),
      .level      (q_level)
   );

   // bit packer back
   hse_back #(
      .MAX_CODE_LEN (MAX_CODE_LEN)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   // queue never overflows
   assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_level < QLVL_W'(QUEUE_DEPTH)) || q_pop)
      else $error("job queue overflow");

   // no pop from an empty queue
   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("pop from empty job queue");

   // only the flush result carries padding or lacks a byte
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_item.end_of_stream) |->
         (rsp_item.has_byte && (rsp_item.pad_bits == '0)))
      else $error("data result without byte or with padding");

   // an accepted item always finds room downstream
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> (q_level < QLVL_W'(QUEUE_DEPTH)))
      else $error("item accepted with full queue");

endmodule
